// ===== sv/cfw_pkg.sv =====
// ----------------------------------------------------------------------------
// cfw_pkg
// shared types, constants and the crc fold function for the crc16 framer
// ----------------------------------------------------------------------------
package cfw_pkg;

  localparam int unsigned BUFFER_BYTES = 128;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_TOP         = 16'h8000;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd124;
  localparam logic [8:0]  BUFFER_LIMIT    = 9'(BUFFER_BYTES);

  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t KIND_DATA = 2'd0;
  localparam cmd_kind_t KIND_END  = 2'd1;
  localparam cmd_kind_t KIND_ERR  = 2'd2;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic [2:0]  pad;
  } cfw_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cfw_qstat_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/cfw_chan_if.sv =====
// ----------------------------------------------------------------------------
// cfw channel interfaces
// valid/ready channels for payload bytes in and frame bytes out
// ----------------------------------------------------------------------------
interface cfw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
  modport mon    (input valid, input data_byte, input last_byte, input ready);
endinterface

interface cfw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       oversize;

  modport source (output valid, output out_byte, output out_last, output oversize,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input oversize,
                  output ready);
  modport mon    (input valid, input out_byte, input out_last, input oversize,
                  input ready);
endinterface

// ===== sv/cfw_front.sv =====
// ----------------------------------------------------------------------------
// cfw_front
// accepts payload bytes, tracks count, overflow and crc, issues commands
// ----------------------------------------------------------------------------
module cfw_front
  import cfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  cfw_in_if.sink      in_chan,
  input  cfw_qstat_t  qstat,
  output logic        push,
  output cfw_cmd_t    push_cmd
);

  logic [7:0]  max_payload_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        ovf_r, ovf_nxt;

  logic        accept;
  logic [8:0]  limit;
  logic        take;
  logic [15:0] crc_new;
  logic [7:0]  count_new;
  logic [7:0]  total;

  assign in_chan.ready = !qstat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    limit     = ({1'b0, max_payload_r} > BUFFER_LIMIT) ? BUFFER_LIMIT : {1'b0, max_payload_r};
    take      = !ovf_r && ({1'b0, count_r} < limit);
    crc_new   = crc_fold(crc_r, in_chan.data_byte);
    count_new = count_r + 8'd1;
    total     = count_new + 8'd2;

    crc_nxt   = crc_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    push      = 1'b0;
    push_cmd.kind = KIND_DATA;
    push_cmd.data = in_chan.data_byte;
    push_cmd.crc  = crc_new;
    push_cmd.pad  = 3'd4 - {1'b0, total[1:0]};

    if (accept) begin
      if (in_chan.last_byte) begin
        crc_nxt   = 16'h0000;
        count_nxt = 8'd0;
        ovf_nxt   = 1'b0;
        push      = 1'b1;
        push_cmd.kind = take ? KIND_END : KIND_ERR;
      end else if (take) begin
        crc_nxt   = crc_new;
        count_nxt = count_new;
        push      = 1'b1;
      end else begin
        ovf_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      crc_r         <= 16'h0000;
      count_r       <= 8'd0;
      ovf_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== sv/cfw_queue.sv =====
// ----------------------------------------------------------------------------
// cfw_queue
// small command queue between the front and the back
// ----------------------------------------------------------------------------
module cfw_queue
  import cfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cfw_cmd_t    push_cmd,
  input  logic        pop,
  output cfw_cmd_t    head,
  output cfw_qstat_t  qstat
);

  cfw_cmd_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/cfw_back.sv =====
// ----------------------------------------------------------------------------
// cfw_back
// expands each command into frame bytes through the output register
// ----------------------------------------------------------------------------
module cfw_back
  import cfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfw_cmd_t    head,
  input  cfw_qstat_t  qstat,
  output logic        pop,
  cfw_out_if.source   out_chan
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       oversize_r;

  logic       advance;
  logic       final_step;
  logic [7:0] byte_sel;
  logic       last_sel;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_last = out_last_r;
  assign out_chan.oversize = oversize_r;

  always_comb begin
    advance    = !qstat.empty && (!out_valid_r || out_chan.ready);
    final_step = 1'b1;
    byte_sel   = 8'h00;
    last_sel   = 1'b0;
    unique case (head.kind)
      KIND_DATA: begin
        byte_sel = head.data;
      end
      KIND_END: begin
        final_step = (step_r == head.pad + 3'd2);
        last_sel   = final_step;
        unique case (step_r)
          3'd0:    byte_sel = head.data;
          3'd1:    byte_sel = head.crc[15:8];
          3'd2:    byte_sel = head.crc[7:0];
          default: byte_sel = 8'h00;
        endcase
      end
      KIND_ERR: begin
        last_sel = 1'b1;
      end
      default: begin
        last_sel = 1'b1;
      end
    endcase
    pop      = advance && final_step;
    step_nxt = step_r;
    if (advance) begin
      step_nxt = final_step ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
      oversize_r <= (head.kind == KIND_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/crc16_word_padded_framer.sv =====
// ----------------------------------------------------------------------------
// crc16_word_padded_framer
// passes payload bytes through, appends crc-16 and zero pad to a word multiple
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  in_chan   sink       data_byte, last_byte
//  out_chan  source     out_byte, out_last, oversize
//  cfg_*     input      max_payload write (cfg_we, cfg_wdata)
//
//  one payload byte per cycle unless the input stalls, crc folded in the front
//  a frame end emits the last payload byte, crc high, crc low and 1-4 pad bytes,
//  or a single oversize error transaction instead
//  input stalls only while the two-entry command queue is full
//  synchronous reset clears frame state and sets max_payload to 124
// ----------------------------------------------------------------------------
module crc16_word_padded_framer
  import cfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  cfw_in_if.sink     in_chan,
  cfw_out_if.source  out_chan
);

  logic       push;
  cfw_cmd_t   push_cmd;
  logic       pop;
  cfw_cmd_t   head;
  cfw_qstat_t qstat;

  cfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  cfw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== sv/cfw_checker.sv =====
// ----------------------------------------------------------------------------
// cfw_checker
// port-level checks on the framer channels
// ----------------------------------------------------------------------------
module cfw_checker (
  input logic        clk,
  input logic        rst_n,
  cfw_in_if.sink     in_chan,
  cfw_out_if.source  out_chan
);

  // error transaction always closes the frame with a zero byte
  a_ovs_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.oversize |-> out_chan.out_last && out_chan.out_byte == 8'h00)
    else $error("oversize transaction malformed");

  // after reset no output pending and input open
  a_reset_state: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_chan.valid && in_chan.ready)
    else $error("bad state after reset");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable(out_chan.out_byte) && $stable(out_chan.out_last)
      && $stable(out_chan.oversize))
    else $error("output changed while stalled");

  // an idle output with no input taken stays idle
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid && !(in_chan.valid && in_chan.ready) && !$past(in_chan.valid)
      && $past(rst_n) && !$past(out_chan.valid) |=> !out_chan.valid)
    else $error("unexpected output");

endmodule

bind crc16_word_padded_framer cfw_checker u_cfw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
